FILE: hdl/mf_pkg.sv
// shared types, constants and compare helpers of the 3x3 median filter
package mf_pkg;

  localparam int unsigned PixW        = 8;
  localparam int unsigned RowW        = 12;
  localparam int unsigned WidthRegW   = 11;
  localparam int unsigned HeightRegW  = 13;
  localparam int unsigned CfgW        = 13;
  localparam int unsigned DefMaxWidth = 1024;
  localparam int unsigned WidthReset  = 1024;
  localparam int unsigned HeightReset = 1024;
  localparam int unsigned MaxHeight   = 4096;
  localparam int unsigned LineW       = 2 * PixW;

  // register indexes
  localparam logic RegImageWidth  = 1'b0;
  localparam logic RegImageHeight = 1'b1;

  // result slots of one pixel, in emission order
  localparam int unsigned SlotCenter = 0;
  localparam int unsigned SlotRight  = 1;
  localparam int unsigned SlotOwn    = 2;
  localparam int unsigned SlotN      = 3;

  typedef logic [PixW-1:0] pix_t;
  typedef logic [2:0][PixW-1:0] pix3_t;

  typedef struct packed {
    pix3_t raw;
    pix3_t srt;
  } col_t;

  typedef struct packed {
    logic [RowW-1:0]  row;
    logic [SlotN-1:0] mask;
    logic             interior;
    logic             frame;
  } meta_t;

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
    return max2(max2(a, b), c);
  endfunction

  function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
    return min2(min2(a, b), c);
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic pix3_t sort3(input pix3_t x);
    pix3_t s;
    pix_t  t;
    s = x;
    if (s[0] > s[1]) begin
      s[0] = x[1];
      s[1] = x[0];
    end
    if (s[1] > s[2]) begin
      s[2] = s[1];
      s[1] = x[2];
    end
    if (s[0] > s[1]) begin
      t    = s[1];
      s[1] = s[0];
      s[0] = t;
    end
    return s;
  endfunction

endpackage

FILE: hdl/mf_line_mem.sv
// two-row line store, one read and one write a cycle, read-during-write forwarding
module mf_line_mem #(
  parameter int unsigned Depth = mf_pkg::DefMaxWidth,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rd_en_i,
  input  logic [AddrW-1:0]          rd_addr_i,
  input  logic                      wr_en_i,
  input  logic [AddrW-1:0]          wr_addr_i,
  input  logic [mf_pkg::LineW-1:0]  wr_data_i,
  output logic [mf_pkg::LineW-1:0]  rd_data_o
);

  logic [mf_pkg::LineW-1:0] mem [Depth];
  logic [mf_pkg::LineW-1:0] rd_q;
  logic [mf_pkg::LineW-1:0] fwd_data_q;
  logic                     fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q       <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule

FILE: hdl/mf_cell.sv
// one window column cell: holds raw and sorted pixels, shifts to its neighbor
module mf_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  mf_pkg::col_t  col_i,
  output mf_pkg::col_t  col_o
);

  mf_pkg::col_t col_q;
  mf_pkg::col_t col_d;

  always_comb begin
    col_d = col_q;
    if (shift_i) begin
      col_d = col_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

  assign col_o = col_q;

endmodule

FILE: hdl/mf_median.sv
// first median level over three sorted columns: max of lows, median of mids, min of highs
module mf_median (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  mf_pkg::col_t [2:0]       cols_i,
  output mf_pkg::pix_t             lo_o,
  output mf_pkg::pix_t             md_o,
  output mf_pkg::pix_t             hi_o
);

  mf_pkg::pix_t lo_q, md_q, hi_q;
  mf_pkg::pix_t lo_d, md_d, hi_d;

  always_comb begin
    lo_d = mf_pkg::max3(cols_i[0].srt[0], cols_i[1].srt[0], cols_i[2].srt[0]);
    md_d = mf_pkg::med3(cols_i[0].srt[1], cols_i[1].srt[1], cols_i[2].srt[1]);
    hi_d = mf_pkg::min3(cols_i[0].srt[2], cols_i[1].srt[2], cols_i[2].srt[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q <= lo_d;
      md_q <= md_d;
      hi_q <= hi_d;
    end
  end

  assign lo_o = lo_q;
  assign md_o = md_q;
  assign hi_o = hi_q;

endmodule

FILE: hdl/median_filter_3x3.sv
// top level of the 3x3 median filter over a raster pixel stream
//
// Input channel: one 8-bit grey pixel per transfer, in raster order, frames of
// image_width x image_height (configuration registers 0 and 1; a write to either
// restarts the frame at row 0, column 0). Output channel: one filtered pixel per
// transfer with its row and column; interior pixels carry the median of their
// nine neighbors, border pixels pass unchanged. Every pixel is emitted once.
// A pixel transfer causes zero to three results: the pixel up and to the left,
// the pixel above at the end of a row, and the pixel itself in the last row.
// run_last marks the last result of a pixel, frame_done the bottom-right pixel.
// Pipeline: the results of a pixel pass through the line store read, the window column
// cells, the first median level and the output register. Throughput: one pixel per cycle
// while the output is not stalled; a pixel with two or three results holds the output
// port, and so the pixel input, until its last result is taken.
// Reset: 1024 x 1024 frame, counters and window cleared; the line store is not
// cleared and its contents are only used where the current frame has written them.
// A stalled output keeps its result and back-pressures through the pipeline;
// input is taken as long as a stage frees up in the same cycle.
module median_filter_3x3 #(
  parameter int unsigned MAX_WIDTH = mf_pkg::DefMaxWidth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [mf_pkg::CfgW-1:0]            cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [mf_pkg::PixW-1:0]            pixel_in_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [mf_pkg::RowW-1:0]            out_row_o,
  output logic [$clog2(MAX_WIDTH)-1:0]       out_col_o,
  output logic [mf_pkg::PixW-1:0]            out_value_o,
  output logic                               run_last_o,
  output logic                               frame_done_o
);

  localparam int unsigned ColW   = $clog2(MAX_WIDTH);
  localparam int unsigned ResetW = (MAX_WIDTH < mf_pkg::WidthReset) ? MAX_WIDTH
                                                                     : mf_pkg::WidthReset;
  localparam int unsigned RowW   = mf_pkg::RowW;

  // configuration and position
  logic [ColW-1:0] lastc_q, lastc_d;
  logic [RowW-1:0] lastr_q, lastr_d;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;

  logic [mf_pkg::WidthRegW-1:0]  cfg_w;
  logic [mf_pkg::HeightRegW-1:0] cfg_h;

  // handshake
  logic accept;
  logic out_free;
  logic s0_adv, s0_free;
  logic s1_adv, s1_free;
  logic s2_take, s2_adv, s2_free;

  // stage 0: line store read
  logic                 s0_valid_q;
  mf_pkg::meta_t        s0_meta_q, meta_d;
  logic [ColW-1:0]      s0_col_q;
  mf_pkg::pix_t         s0_px_q;
  logic [mf_pkg::LineW-1:0] line_rd;
  mf_pkg::pix_t         top, mid;
  mf_pkg::col_t         new_col;

  // stage 1: window cells
  logic                 s1_valid_q;
  mf_pkg::meta_t        s1_meta_q;
  logic [ColW-1:0]      s1_col_q;
  mf_pkg::pix_t         s1_px_q, s1_mid_q;
  mf_pkg::col_t [2:0]   cols;

  // stage 2: result group
  logic                 s2_valid_q, s2_valid_d;
  logic [mf_pkg::SlotN-1:0] s2_mask_q, s2_mask_d, s2_rem;
  mf_pkg::meta_t        s2_meta_q;
  logic [ColW-1:0]      s2_col_q;
  mf_pkg::pix_t         s2_px_q, s2_mid_q, s2_win4_q;
  mf_pkg::pix_t         lo, md, hi;

  // output register
  logic                 out_valid_q, out_valid_d;
  logic [RowW-1:0]      out_row_q, out_row_d;
  logic [ColW-1:0]      out_col_q, out_col_d;
  mf_pkg::pix_t         out_value_q, out_value_d;
  logic                 run_last_q, run_last_d;
  logic                 frame_done_q, frame_done_d;

  assign cfg_w = cfg_data_i[mf_pkg::WidthRegW-1:0];
  assign cfg_h = cfg_data_i[mf_pkg::HeightRegW-1:0];

  // handshake chain
  assign out_free = !out_valid_q || !out_stall_i;
  assign s2_rem   = s2_mask_q & (s2_mask_q - mf_pkg::SlotN'(1));
  assign s2_take  = s2_valid_q && out_free;
  assign s2_adv   = s2_take && (s2_rem == '0);
  assign s2_free  = !s2_valid_q || s2_adv;
  assign s1_adv   = s1_valid_q && s2_free;
  assign s1_free  = !s1_valid_q || s1_adv;
  assign s0_adv   = s0_valid_q && s1_free;
  assign s0_free  = !s0_valid_q || s0_adv;
  assign accept   = in_valid_i && s0_free;
  assign in_stall_o = !s0_free;

  // configuration
  always_comb begin
    lastc_d = lastc_q;
    lastr_d = lastr_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        mf_pkg::RegImageWidth: begin
          if (cfg_w == '0) begin
            lastc_d = '0;
          end else if (int'(cfg_w) > MAX_WIDTH) begin
            lastc_d = ColW'(MAX_WIDTH - 1);
          end else begin
            lastc_d = ColW'(cfg_w - mf_pkg::WidthRegW'(1));
          end
        end
        mf_pkg::RegImageHeight: begin
          if (cfg_h == '0) begin
            lastr_d = '0;
          end else if (int'(cfg_h) > mf_pkg::MaxHeight) begin
            lastr_d = RowW'(mf_pkg::MaxHeight - 1);
          end else begin
            lastr_d = RowW'(cfg_h - mf_pkg::HeightRegW'(1));
          end
        end
        default: begin
          lastc_d = lastc_q;
        end
      endcase
    end
  end

  // raster position
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_we_i) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (col_q == lastc_q) begin
        col_d = '0;
        row_d = (row_q == lastr_q) ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_comb begin
    meta_d.row                        = row_q;
    meta_d.mask[mf_pkg::SlotCenter]   = (row_q != '0) && (col_q != '0);
    meta_d.mask[mf_pkg::SlotRight]    = (row_q != '0) && (col_q == lastc_q);
    meta_d.mask[mf_pkg::SlotOwn]      = (row_q == lastr_q);
    meta_d.interior                   = (row_q > RowW'(1)) && (col_q > ColW'(1));
    meta_d.frame                      = (row_q == lastr_q) && (col_q == lastc_q);
  end

  // line store, rows r-2 in the upper byte and r-1 in the lower byte
  mf_line_mem #(
    .Depth (MAX_WIDTH),
    .AddrW (ColW)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .wr_en_i   (s0_adv),
    .wr_addr_i (s0_col_q),
    .wr_data_i ({mid, s0_px_q}),
    .rd_data_o (line_rd)
  );

  assign top = line_rd[mf_pkg::LineW-1:mf_pkg::PixW];
  assign mid = line_rd[mf_pkg::PixW-1:0];

  always_comb begin
    new_col.raw[0] = top;
    new_col.raw[1] = mid;
    new_col.raw[2] = s0_px_q;
    new_col.srt    = mf_pkg::sort3(new_col.raw);
  end

  // window: cell 2 newest column, cell 0 oldest
  mf_cell u_cell2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s0_adv),
    .col_i   (new_col),
    .col_o   (cols[2])
  );

  mf_cell u_cell1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s0_adv),
    .col_i   (cols[2]),
    .col_o   (cols[1])
  );

  mf_cell u_cell0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s0_adv),
    .col_i   (cols[1]),
    .col_o   (cols[0])
  );

  mf_median u_median (
    .clk_i  (clk_i),
    .en_i   (s1_adv),
    .cols_i (cols),
    .lo_o   (lo),
    .md_o   (md),
    .hi_o   (hi)
  );

  // result group and output register
  always_comb begin
    s2_valid_d   = s2_valid_q;
    s2_mask_d    = s2_mask_q;
    out_valid_d  = out_valid_q;
    out_row_d    = out_row_q;
    out_col_d    = out_col_q;
    out_value_d  = out_value_q;
    run_last_d   = run_last_q;
    frame_done_d = frame_done_q;

    if (out_free) begin
      out_valid_d = s2_valid_q;
    end
    if (s2_take) begin
      s2_mask_d    = s2_rem;
      run_last_d   = (s2_rem == '0);
      frame_done_d = (s2_rem == '0) && s2_meta_q.frame;
      if (s2_mask_q[mf_pkg::SlotCenter]) begin
        out_row_d   = s2_meta_q.row - RowW'(1);
        out_col_d   = s2_col_q - ColW'(1);
        out_value_d = s2_meta_q.interior ? mf_pkg::med3(lo, md, hi) : s2_win4_q;
      end else if (s2_mask_q[mf_pkg::SlotRight]) begin
        out_row_d   = s2_meta_q.row - RowW'(1);
        out_col_d   = s2_col_q;
        out_value_d = s2_mid_q;
      end else begin
        out_row_d   = s2_meta_q.row;
        out_col_d   = s2_col_q;
        out_value_d = s2_px_q;
      end
    end

    if (s1_adv) begin
      s2_valid_d = (s1_meta_q.mask != '0);
      s2_mask_d  = s1_meta_q.mask;
    end else if (s2_adv) begin
      s2_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lastc_q     <= ColW'(ResetW - 1);
      lastr_q     <= RowW'(mf_pkg::HeightReset - 1);
      col_q       <= '0;
      row_q       <= '0;
      s0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s2_mask_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      lastc_q     <= lastc_d;
      lastr_q     <= lastr_d;
      col_q       <= col_d;
      row_q       <= row_d;
      s0_valid_q  <= accept || (s0_valid_q && !s0_adv);
      s1_valid_q  <= s0_adv || (s1_valid_q && !s1_adv);
      s2_valid_q  <= s2_valid_d;
      s2_mask_q   <= s2_mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_meta_q <= meta_d;
      s0_col_q  <= col_q;
      s0_px_q   <= pixel_in_i;
    end
    if (s0_adv) begin
      s1_meta_q <= s0_meta_q;
      s1_col_q  <= s0_col_q;
      s1_px_q   <= s0_px_q;
      s1_mid_q  <= mid;
    end
    if (s1_adv) begin
      s2_meta_q <= s1_meta_q;
      s2_col_q  <= s1_col_q;
      s2_px_q   <= s1_px_q;
      s2_mid_q  <= s1_mid_q;
      s2_win4_q <= cols[1].raw[1];
    end
    out_row_q    <= out_row_d;
    out_col_q    <= out_col_d;
    out_value_q  <= out_value_d;
    run_last_q   <= run_last_d;
    frame_done_q <= frame_done_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_row_o    = out_row_q;
  assign out_col_o    = out_col_q;
  assign out_value_o  = out_value_q;
  assign run_last_o   = run_last_q;
  assign frame_done_o = frame_done_q;

  // a held group always has a result left
  a_group_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> (s2_mask_q != '0))
    else $error("empty result group held");

  // further results of the same pixel are still queued
  a_run_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !run_last_o) |-> s2_valid_q)
    else $error("run not closed but no result pending");

  // the frame ends on the bottom-right pixel, as the last result of its pixel
  a_frame_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_done_o) |->
      (run_last_o && out_row_o == lastr_q && out_col_o == lastc_q))
    else $error("frame end away from the last pixel");

endmodule

FILE: tb/sv/tb_median_filter_3x3.sv
// testbench of the 3x3 median filter: directed and random frames checked against a pixel predictor
module tb_median_filter_3x3;
  timeunit 1ns;
  timeprecision 1ps;

  import mf_pkg::*;

  localparam int unsigned MaxWidth     = DefMaxWidth;
  localparam int unsigned ColW         = $clog2(MaxWidth);
  localparam int unsigned WinSize      = 9;
  localparam int unsigned WinMid       = 4;
  localparam time         HalfPeriod   = 10ns;
  localparam int unsigned ResetCycles  = 12;
  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned HoldCycles   = 100;
  localparam int unsigned RandomItems  = 270;
  localparam int unsigned MaxReports   = 50;
  localparam time         RunLimit     = 10ms;

  typedef enum int unsigned {StallNone, StallLight, StallHeavy, StallPeriodic} stall_mode_e;
  typedef enum int unsigned {PixAny, PixBinary, PixNarrow} pix_flavor_e;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    pix_t            value;
    logic            last;
    logic            done;
  } filt_px_t;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                cfg_we_i     = 1'b0;
  logic                cfg_idx_i    = RegImageWidth;
  logic [CfgW-1:0]     cfg_data_i   = '0;
  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic [PixW-1:0]     pixel_in_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic [RowW-1:0]     out_row_o;
  logic [ColW-1:0]     out_col_o;
  logic [PixW-1:0]     out_value_o;
  logic                run_last_o;
  logic                frame_done_o;

  // predictor state
  logic [WidthRegW-1:0]  width_reg  = WidthRegW'(WidthReset);
  logic [HeightRegW-1:0] height_reg = HeightRegW'(HeightReset);
  int unsigned           row_pos    = 0;
  int unsigned           col_pos    = 0;
  pix_t                  line_up1 [MaxWidth] = '{default: '0};
  pix_t                  line_up2 [MaxWidth] = '{default: '0};
  pix_t                  win [WinSize]       = '{default: '0};
  filt_px_t              filtered_q [$];

  int unsigned err_count  = 0;
  int unsigned burst_left = 0;
  bit          hold_req   = 1'b0;
  int unsigned hold_left  = 0;
  int unsigned mode_left  = 0;
  stall_mode_e stall_mode = StallNone;
  filt_px_t    want_px;

  median_filter_3x3 i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .pixel_in_i,
    .out_valid_o,
    .out_stall_i,
    .out_row_o,
    .out_col_o,
    .out_value_o,
    .run_last_o,
    .frame_done_o
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  task automatic report_error(input string msg);
    err_count++;
    if (err_count <= MaxReports) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MaxWidth) return MaxWidth;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg == 0) return 1;
    if (height_reg > MaxHeight) return MaxHeight;
    return 32'(height_reg);
  endfunction

  // value with at most four smaller and at least five smaller-or-equal
  function automatic pix_t window_median();
    int unsigned lt;
    int unsigned le;
    for (int i = 0; i < WinSize; i++) begin
      lt = 0;
      le = 0;
      for (int j = 0; j < WinSize; j++) begin
        if (win[j] < win[i]) lt++;
        if (win[j] <= win[i]) le++;
      end
      if (lt <= WinMid && le > WinMid) return win[i];
    end
    return win[WinMid];
  endfunction

  task automatic predict_pixel(input pix_t px);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    int unsigned n;
    pix_t        top;
    pix_t        mid;
    filt_px_t    res [3];
    w = eff_width();
    h = eff_height();
    r = row_pos;
    c = col_pos;
    n = 0;
    if (c >= w) c = w - 1;
    if (r >= h) r = h - 1;
    top = line_up2[c];
    mid = line_up1[c];
    win[0] = win[1]; win[1] = win[2]; win[2] = top;
    win[3] = win[4]; win[4] = win[5]; win[5] = mid;
    win[6] = win[7]; win[7] = win[8]; win[8] = px;
    line_up2[c] = mid;
    line_up1[c] = px;
    if (r >= 1) begin
      if (c >= 1) begin
        res[n] = '{row: RowW'(r - 1), col: ColW'(c - 1),
                   value: (r >= 2 && r < h && c >= 2) ? window_median() : win[WinMid],
                   last: 1'b0, done: 1'b0};
        n++;
      end
      if (c == w - 1) begin
        res[n] = '{row: RowW'(r - 1), col: ColW'(c), value: mid, last: 1'b0, done: 1'b0};
        n++;
      end
    end
    if (r == h - 1) begin
      res[n] = '{row: RowW'(r), col: ColW'(c), value: px, last: 1'b0, done: 1'b0};
      n++;
    end
    if (n > 0) begin
      res[n-1].last = 1'b1;
      if (r == h - 1 && c == w - 1) res[n-1].done = 1'b1;
    end
    for (int unsigned i = 0; i < n; i++) filtered_q.push_back(res[i]);
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  function automatic pix_t rand_pixel(input pix_flavor_e flavor);
    case (flavor)
      PixAny:    return pix_t'($urandom_range(0, 255));
      PixBinary: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default:   return pix_t'(8'h7E + $urandom_range(0, 3));
    endcase
  endfunction

  task automatic send_pixel(input pix_t px);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
    end
    burst_left--;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_in_i <= px;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_pixel(px);
  endtask

  task automatic send_pixels(input int unsigned count, input pix_flavor_e flavor);
    for (int unsigned i = 0; i < count; i++) send_pixel(rand_pixel(flavor));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [CfgW-1:0] value);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegImageWidth) begin
      width_reg = value[WidthRegW-1:0];
    end else begin
      height_reg = value[HeightRegW-1:0];
    end
    row_pos = 0;
    col_pos = 0;
  endtask

  task automatic set_geometry(input logic [CfgW-1:0] w, input logic [CfgW-1:0] h);
    if ($urandom_range(0, 1)) begin
      write_reg(RegImageWidth, w);
      write_reg(RegImageHeight, h);
    end else begin
      write_reg(RegImageHeight, h);
      write_reg(RegImageWidth, w);
    end
  endtask

  // no result may come out of the first row of the 1024 x 1024 frame
  task automatic test_reset_geometry();
    send_pixels(4, PixAny);
  endtask

  task automatic test_corner_values();
    pix_t vals [12];
    vals = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'hFF, 8'h00, 8'hAA, 8'h55,
             8'h0F, 8'hF0, 8'h01, 8'h80};
    set_geometry(4, 3);
    foreach (vals[i]) send_pixel(vals[i]);
  endtask

  task automatic test_frame_wrap();
    set_geometry(3, 3);
    send_pixels(18, PixAny);
  endtask

  task automatic test_restart_on_write();
    set_geometry(4, 3);
    send_pixels(18, PixAny);
    write_reg(RegImageWidth, 4);
    send_pixels(17, PixNarrow);
    write_reg(RegImageHeight, 3);
    send_pixels(12, PixAny);
  endtask

  task automatic test_width_limits();
    set_geometry(0, 3);
    send_pixels(6, PixAny);
    set_geometry(13'h1801, 1);
    send_pixels(3, PixAny);
    write_reg(RegImageWidth, 13'h1FFF);
    send_pixels(10, PixAny);
    write_reg(RegImageWidth, CfgW'(MaxWidth));
    send_pixels(6, PixAny);
  endtask

  task automatic test_height_limits();
    set_geometry(3, 0);
    send_pixels(6, PixAny);
    set_geometry(1, 13'h1FFF);
    send_pixels(12, PixAny);
    set_geometry(2, CfgW'(MaxHeight));
    send_pixels(8, PixAny);
  endtask

  task automatic test_backpressure();
    set_geometry(6, 4);
    hold_req = 1'b1;
    send_pixels(48, PixAny);
  endtask

  task automatic test_random_frames();
    int unsigned sent;
    int unsigned pick;
    int unsigned w;
    int unsigned h;
    int unsigned count;
    pix_flavor_e flavor;
    sent = 0;
    while (sent < RandomItems) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        h = $urandom_range(1, 4);
        if ($urandom_range(0, 1)) begin
          w = 0;
          count = h * $urandom_range(1, 3);
        end else begin
          w = $urandom_range(MaxWidth + 1, (1 << WidthRegW) - 1);
          count = $urandom_range(1, 24);
        end
      end else if (pick == 1) begin
        w = $urandom_range(1, 6);
        if ($urandom_range(0, 1)) begin
          h = 0;
          count = w * $urandom_range(1, 3);
        end else begin
          h = $urandom_range(MaxHeight + 1, (1 << HeightRegW) - 1);
          count = $urandom_range(w, 40);
        end
      end else if (pick <= 3) begin
        w = $urandom_range(13, 48);
        h = $urandom_range(2, 4);
        count = w * h;
      end else begin
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 8);
        count = w * h * $urandom_range(1, 3);
        if ($urandom_range(0, 4) == 0) count = $urandom_range(1, count);
      end
      flavor = ($urandom_range(0, 9) < 6) ? PixAny : pix_flavor_e'($urandom_range(1, 2));
      set_geometry(CfgW'(w), CfgW'(h));
      send_pixels(count, flavor);
      sent += count;
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(10, 150);
      end
      mode_left--;
      case (stall_mode)
        StallNone:  out_stall_i <= 1'b0;
        StallLight: out_stall_i <= ($urandom_range(0, 3) == 0);
        StallHeavy: out_stall_i <= ($urandom_range(0, 9) < 6);
        default:    out_stall_i <= (mode_left % 4 < 2);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (filtered_q.size() == 0) begin
        report_error($sformatf("unexpected transfer row %0d col %0d value %0d",
                               out_row_o, out_col_o, out_value_o));
      end else begin
        want_px = filtered_q.pop_front();
        if (out_row_o !== want_px.row)
          report_error($sformatf("row: got %0d, want %0d", out_row_o, want_px.row));
        if (out_col_o !== want_px.col)
          report_error($sformatf("(%0d) col: got %0d, want %0d", want_px.row, out_col_o,
                                 want_px.col));
        if (out_value_o !== want_px.value)
          report_error($sformatf("(%0d,%0d) value: got %0d, want %0d", want_px.row,
                                 want_px.col, out_value_o, want_px.value));
        if (run_last_o !== want_px.last)
          report_error($sformatf("(%0d,%0d) run_last: got %b, want %b", want_px.row,
                                 want_px.col, run_last_o, want_px.last));
        if (frame_done_o !== want_px.done)
          report_error($sformatf("(%0d,%0d) frame_done: got %b, want %b", want_px.row,
                                 want_px.col, frame_done_o, want_px.done));
      end
    end
  end

  initial begin
    #(RunLimit);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_geometry();
    test_corner_values();
    test_frame_wrap();
    test_restart_on_write();
    test_width_limits();
    test_height_limits();
    test_backpressure();
    test_random_frames();
    drain();
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/mf_pkg.sv
hdl/mf_line_mem.sv
hdl/mf_cell.sv
hdl/mf_median.sv
hdl/median_filter_3x3.sv
tb/sv/tb_median_filter_3x3.sv
